[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL
// Clocked, reset-qualified concurrent assertion wrappers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define KFR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define KFR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/kfr_pkg.sv]
// ---------------------------------------------------------------------------
// kfr_pkg
// Types and constants of the keyed FIFO with removal.
// ---------------------------------------------------------------------------
package kfr_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [KEY_BITS-1:0]   entry_key;
      logic [VALUE_BITS-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] front_value;
      logic                  is_empty;
      logic [COUNT_BITS-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic                 done;
      logic                 found;
      logic [SLOT_BITS-1:0] slot;
   } scan_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_PUSH_A,
      S_PUSH_B,
      S_LINK_RD,
      S_LINK_WR,
      S_FRONT_RD,
      S_RESP
   } state_type;

endpackage

[rtl/kfr_keys.sv]
// ---------------------------------------------------------------------------
// kfr_keys
// Key store with a sequential lookup: one slot read per cycle, compare on
// the registered read data, done pulse with hit flag and slot.
// ---------------------------------------------------------------------------
module kfr_keys (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               scan_go,
   input  logic [kfr_pkg::KEY_BITS-1:0]       scan_key,
   input  logic [kfr_pkg::CAPACITY-1:0]       slot_valid,
   input  logic                               wr_en,
   input  logic [kfr_pkg::SLOT_BITS-1:0]      wr_slot,
   input  logic [kfr_pkg::KEY_BITS-1:0]       wr_key,
   output kfr_pkg::scan_type                  scan
);

   logic [kfr_pkg::KEY_BITS-1:0]  key_mem [kfr_pkg::CAPACITY];
   logic [kfr_pkg::KEY_BITS-1:0]  key_rd_ff;
   logic [kfr_pkg::SLOT_BITS-1:0] addr_ff, addr_in;
   logic [kfr_pkg::SLOT_BITS-1:0] cmp_slot_ff, cmp_slot_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic                          run_ff, run_in;
   kfr_pkg::scan_type             scan_ff, scan_in;
   logic                          hit, last;

   assign hit  = cmp_vld_ff && slot_valid[cmp_slot_ff] && (key_rd_ff == scan_key);
   assign last = cmp_vld_ff && (cmp_slot_ff == kfr_pkg::SLOT_BITS'(kfr_pkg::CAPACITY - 1));

   always_comb begin
      addr_in     = addr_ff;
      cmp_slot_in = cmp_slot_ff;
      cmp_vld_in  = cmp_vld_ff;
      run_in      = run_ff;
      scan_in     = '{done: 1'b0, found: scan_ff.found, slot: scan_ff.slot};
      if (scan_go) begin
         run_in     = 1'b1;
         addr_in    = '0;
         cmp_vld_in = 1'b0;
      end else if (run_ff) begin
         if (hit || last) begin
            run_in     = 1'b0;
            cmp_vld_in = 1'b0;
            scan_in    = '{done: 1'b1, found: hit, slot: cmp_slot_ff};
         end else begin
            cmp_vld_in  = 1'b1;
            cmp_slot_in = addr_ff;
            addr_in     = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         cmp_vld_ff <= 1'b0;
         scan_ff    <= '0;
      end else begin
         run_ff     <= run_in;
         cmp_vld_ff <= cmp_vld_in;
         scan_ff    <= scan_in;
      end
      addr_ff     <= addr_in;
      cmp_slot_ff <= cmp_slot_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_slot] <= wr_key;
      end
      key_rd_ff <= key_mem[addr_ff];
   end

   assign scan = scan_ff;

endmodule

[rtl/keyed_fifo_with_removal.sv]
// ---------------------------------------------------------------------------
// keyed_fifo_with_removal
// FIFO of unique-key entries with push back, pop front and remove by key.
// ---------------------------------------------------------------------------
// Usage:
//   Request: drive req_data and raise start while busy is low; the beat is
//   taken on that edge and busy rises on the next cycle until the result.
//   Response: rsp_strobe is high for one cycle with rsp_data; the receiver
//   must take it then, there is no back-pressure.
//   States per request, from the start edge to the strobe in S_RESP:
//     pop    : S_LINK_RD, S_LINK_WR, S_FRONT_RD, S_RESP
//     empty pop, unused opcode : S_FRONT_RD, S_RESP
//     remove : S_SEARCH, then S_LINK_RD, S_LINK_WR (on a hit), S_FRONT_RD, S_RESP
//     push   : S_SEARCH, S_PUSH_A, S_PUSH_B (if taken), S_FRONT_RD, S_RESP
//   The key lookup reads one slot of the key memory per cycle, one request
//   at a time. A pop or remove reads and then writes the link memories; the
//   front value is read from the value memory before the result.
//   Reset: synchronous; the queue comes up empty and busy low. Memories are
//   not cleared, the per-slot valid flags are.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_fifo_with_removal (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kfr_pkg::req_type req_data,
   output logic             rsp_strobe,
   output kfr_pkg::rsp_type rsp_data
);

   localparam int SB = kfr_pkg::SLOT_BITS;
   localparam int CB = kfr_pkg::COUNT_BITS;

   kfr_pkg::state_type state_ff, state_in;
   kfr_pkg::req_type   req_ff, req_in;
   logic [1:0]         status_ff, status_in;
   logic [SB-1:0]      slot_ff, slot_in;
   logic [SB-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CB-1:0]      count_ff, count_in;
   logic [kfr_pkg::CAPACITY-1:0] valid_ff, valid_in;

   logic [kfr_pkg::VALUE_BITS-1:0] val_mem [kfr_pkg::CAPACITY];
   logic [SB-1:0]                  prev_mem [kfr_pkg::CAPACITY];
   logic [SB-1:0]                  next_mem [kfr_pkg::CAPACITY];
   logic [kfr_pkg::VALUE_BITS-1:0] val_rd_ff;
   logic [SB-1:0]                  prev_rd_ff, next_rd_ff;

   logic          scan_go, key_we, val_we, prev_we, next_we;
   logic [SB-1:0] prev_wa, prev_wd, next_wa, next_wd;
   logic [SB-1:0] free_slot;
   logic          full;
   kfr_pkg::scan_type scan;

   kfr_keys u_keys (
      .clock      (clock),
      .reset      (reset),
      .scan_go    (scan_go),
      .scan_key   (req_ff.entry_key),
      .slot_valid (valid_ff),
      .wr_en      (key_we),
      .wr_slot    (slot_ff),
      .wr_key     (req_ff.entry_key),
      .scan       (scan)
   );

   always_comb begin
      free_slot = '0;
      for (int i = kfr_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SB'(i);
         end
      end
   end

   assign full = (count_ff == CB'(kfr_pkg::CAPACITY));

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      scan_go   = 1'b0;
      key_we    = 1'b0;
      val_we    = 1'b0;
      prev_we   = 1'b0;
      prev_wa   = slot_ff;
      prev_wd   = tail_ff;
      next_we   = 1'b0;
      next_wa   = slot_ff;
      next_wd   = '0;
      unique case (state_ff)
         kfr_pkg::S_IDLE: begin
            if (start) begin
               req_in    = req_data;
               status_in = kfr_pkg::ST_OK;
               priority if (req_data.opcode == kfr_pkg::OP_PUSH ||
                            req_data.opcode == kfr_pkg::OP_REMOVE) begin
                  scan_go  = 1'b1;
                  state_in = kfr_pkg::S_SEARCH;
               end else if (req_data.opcode == kfr_pkg::OP_POP) begin
                  if (count_ff == '0) begin
                     status_in = kfr_pkg::ST_NOT_FOUND;
                     state_in  = kfr_pkg::S_FRONT_RD;
                  end else begin
                     slot_in  = head_ff;
                     state_in = kfr_pkg::S_LINK_RD;
                  end
               end else begin
                  state_in = kfr_pkg::S_FRONT_RD;
               end
            end
         end
         kfr_pkg::S_SEARCH: begin
            if (scan.done) begin
               priority if (req_ff.opcode == kfr_pkg::OP_REMOVE) begin
                  if (scan.found) begin
                     slot_in  = scan.slot;
                     state_in = kfr_pkg::S_LINK_RD;
                  end else begin
                     status_in = kfr_pkg::ST_NOT_FOUND;
                     state_in  = kfr_pkg::S_FRONT_RD;
                  end
               end else if (scan.found) begin
                  status_in = kfr_pkg::ST_DUPLICATE;
                  state_in  = kfr_pkg::S_FRONT_RD;
               end else if (full) begin
                  status_in = kfr_pkg::ST_FULL;
                  state_in  = kfr_pkg::S_FRONT_RD;
               end else begin
                  slot_in  = free_slot;
                  state_in = kfr_pkg::S_PUSH_A;
               end
            end
         end
         kfr_pkg::S_PUSH_A: begin
            key_we   = 1'b1;
            val_we   = 1'b1;
            prev_we  = 1'b1;
            next_we  = 1'b1;
            state_in = kfr_pkg::S_PUSH_B;
         end
         kfr_pkg::S_PUSH_B: begin
            if (count_ff == '0) begin
               head_in = slot_ff;
            end else begin
               next_we = 1'b1;
               next_wa = tail_ff;
               next_wd = slot_ff;
            end
            tail_in           = slot_ff;
            valid_in[slot_ff] = 1'b1;
            count_in          = count_ff + 1'b1;
            state_in          = kfr_pkg::S_FRONT_RD;
         end
         kfr_pkg::S_LINK_RD: begin
            state_in = kfr_pkg::S_LINK_WR;
         end
         kfr_pkg::S_LINK_WR: begin
            prev_wa = next_rd_ff;
            prev_wd = prev_rd_ff;
            next_wa = prev_rd_ff;
            next_wd = next_rd_ff;
            priority if (count_ff <= CB'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else if (slot_ff == head_ff) begin
               head_in = next_rd_ff;
               prev_we = 1'b1;
            end else if (slot_ff == tail_ff) begin
               tail_in = prev_rd_ff;
               next_we = 1'b1;
            end else begin
               prev_we = 1'b1;
               next_we = 1'b1;
            end
            valid_in[slot_ff] = 1'b0;
            count_in          = count_ff - 1'b1;
            state_in          = kfr_pkg::S_FRONT_RD;
         end
         kfr_pkg::S_FRONT_RD: begin
            state_in = kfr_pkg::S_RESP;
         end
         kfr_pkg::S_RESP: begin
            state_in = kfr_pkg::S_IDLE;
         end
         default: begin
            state_in = kfr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kfr_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[slot_ff] <= req_ff.entry_value;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      val_rd_ff  <= val_mem[head_ff];
      prev_rd_ff <= prev_mem[slot_ff];
      next_rd_ff <= next_mem[slot_ff];
   end

   assign busy                 = (state_ff != kfr_pkg::S_IDLE);
   assign rsp_strobe           = (state_ff == kfr_pkg::S_RESP);
   assign rsp_data.status      = status_ff;
   assign rsp_data.front_value = (count_ff == '0) ? '0 : val_rd_ff;
   assign rsp_data.is_empty    = (count_ff == '0);
   assign rsp_data.occupancy   = count_ff;

   `KFR_ASSERT(a_count_range, count_ff <= CB'(kfr_pkg::CAPACITY), "entry count over capacity")
   `KFR_ASSERT(a_valid_count, $countones(valid_ff) == 32'(count_ff), "valid flags disagree with count")
   `KFR_ASSERT_IMP(a_accept_busy, start && !busy, ##1 busy, "accepted request did not raise busy")
   `KFR_ASSERT_IMP(a_strobe_once, rsp_strobe, ##1 !rsp_strobe, "response strobe held over one cycle")
   `KFR_ASSERT_IMP(a_empty_head, count_ff == '0, head_ff == '0 && tail_ff == '0, "empty queue with stale pointers")

endmodule

[tb/sv/kfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_checker
// Watches request and response beats of the keyed FIFO, keeps its own copy of
// the queue, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module kfr_checker
   import kfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   // queue model: entries in order, oldest first
   logic [KEY_BITS-1:0]   q_keys[$];
   logic [VALUE_BITS-1:0] q_values[$];
   rsp_type               expected_rsps[$];

   assign pending_count = expected_rsps.size();

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch %s got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic rsp_type apply_request(input req_type r);
      rsp_type p;
      int      hit;
      hit = -1;
      foreach (q_keys[i]) if (q_keys[i] == r.entry_key) hit = i;
      p = '0;
      p.status = ST_OK;
      case (r.opcode)
         OP_PUSH: begin
            if (hit >= 0) p.status = ST_DUPLICATE;
            else if (q_keys.size() >= CAPACITY) p.status = ST_FULL;
            else begin
               q_keys.push_back(r.entry_key);
               q_values.push_back(r.entry_value);
            end
         end
         OP_POP: begin
            if (q_keys.size() == 0) p.status = ST_NOT_FOUND;
            else begin
               void'(q_keys.pop_front());
               void'(q_values.pop_front());
            end
         end
         OP_REMOVE: begin
            if (hit < 0) p.status = ST_NOT_FOUND;
            else begin
               q_keys.delete(hit);
               q_values.delete(hit);
            end
         end
         default: ;
      endcase
      p.front_value = q_keys.size() ? q_values[0] : '0;
      p.is_empty    = q_keys.size() == 0;
      p.occupancy   = COUNT_BITS'(q_keys.size());
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count = 0;
         q_keys.delete();
         q_values.delete();
         expected_rsps.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response beat with nothing expected", $time);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.front_value !== want.front_value)
                  report_mismatch("front_value", 64'(rsp_data.front_value),
                                  64'(want.front_value));
               if (rsp_data.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 64'(rsp_data.is_empty), 64'(want.is_empty));
               if (rsp_data.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 64'(rsp_data.occupancy),
                                  64'(want.occupancy));
            end
         end
         if (start && !busy) expected_rsps.push_back(apply_request(req_data));
      end
   end

endmodule

[tb/sv/tb_keyed_fifo_with_removal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_fifo_with_removal
// Directed and random push, pop, remove and unused-opcode beats, random idle
// gaps; the checker predicts every response and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_keyed_fifo_with_removal;
   import kfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   logic [KEY_BITS-1:0] key_pool[8];

   keyed_fifo_with_removal dut (.*);

   kfr_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keyed_fifo_with_removal verification failed");
         $finish;
      end
   end

   // one beat; idle gap first when asked
   task automatic send_beat(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] value, input bit gaps);
      while (gaps && $urandom_range(99) < 34) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{opcode: op, entry_key: key, entry_value: value};
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [1:0] op;
      int         pick;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, extremes, fill past full, duplicate, removes
      send_beat(OP_POP, '0, '0, 0);
      send_beat(OP_REMOVE, '1, '0, 0);
      send_beat(OP_UNUSED, '1, '1, 0);
      send_beat(OP_PUSH, '0, '1, 0);
      send_beat(OP_PUSH, '0, '0, 0);
      send_beat(OP_PUSH, '1, '0, 0);
      for (int i = 2; i < CAPACITY + 1; i++) send_beat(OP_PUSH, i, i * 3, 0);
      send_beat(OP_REMOVE, 7, '0, 0);
      send_beat(OP_REMOVE, '1, '0, 0);
      send_beat(OP_POP, '1, '1, 0);
      send_beat(OP_PUSH, 7, 32'hA5A5_5A5A, 0);
      for (int i = 0; i < CAPACITY; i++) send_beat(OP_POP, '0, '0, 0);

      foreach (key_pool[i]) key_pool[i] = $urandom();
      for (int n = 0; n < 1000; n++) begin
         pick = $urandom_range(99);
         op = pick < 45 ? OP_PUSH : pick < 70 ? OP_POP : pick < 97 ? OP_REMOVE : OP_UNUSED;
         send_beat(op, $urandom_range(3) != 0 ? key_pool[$urandom_range(7)] : $urandom(),
                   $urandom(), !(n >= 400 && n < 550));
         if ($urandom_range(15) == 0) key_pool[$urandom_range(7)] = $urandom();
      end

      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("keyed_fifo_with_removal verification clean");
      else
         $display("keyed_fifo_with_removal verification failed");
      $finish;
   end

endmodule
